@@ design/vssm_pkg.sv @@
// ----------------------------------------------------------------------------
// vssm_pkg
// Types and constants shared by the video sync stability monitor files.
// ----------------------------------------------------------------------------
`default_nettype none

package vssm_pkg;

    // status codes, ordered by priority
    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_INFO = 2'd1,
        ST_MODE = 2'd2,
        ST_ACT  = 2'd3
    } report_code_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MIN_LINES_PROG = 3'd0;
    localparam logic [2:0] REG_MIN_LINES_IL   = 3'd1;
    localparam logic [2:0] REG_LOSS_THR       = 3'd2;
    localparam logic [2:0] REG_STABLE_THR     = 3'd3;
    localparam logic [2:0] REG_LINE_TOL       = 3'd4;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // register reset values
    localparam logic [11:0] RST_MIN_LINES_PROG = 12'd200;
    localparam logic [11:0] RST_MIN_LINES_IL   = 12'd400;
    localparam logic [3:0]  RST_LOSS_THR       = 4'd5;
    localparam logic [3:0]  RST_STABLE_THR     = 4'd1;
    localparam logic [7:0]  RST_LINE_TOL       = 8'd1;

    // vsync classification codes
    localparam logic [1:0] VMODE_IL_CHECK = 2'd1;
    localparam logic [1:0] VMODE_PROG     = 2'd2;

    // bit positions in the line count high byte
    localparam int unsigned LHI_PROG_BIT  = 5;
    localparam int unsigned LHI_MACRO_BIT = 6;

    typedef struct packed {
        logic [11:0] min_lines_prog;
        logic [11:0] min_lines_il;
        logic [3:0]  loss_thr;
        logic [3:0]  stable_thr;
        logic [7:0]  line_tol;
    } cfg_t;

    typedef struct packed {
        logic        sync_state;
        logic [3:0]  loss_counter;
        logic [3:0]  stable_counter;
        logic [15:0] prev_lines;
        logic [11:0] prev_clocks;
        logic        prev_progressive;
    } mon_state_t;

    typedef struct packed {
        logic        sync_detected;
        logic [1:0]  vsync_mode;
        logic [7:0]  line_count_low;
        logic [7:0]  line_count_high;
        logic [7:0]  clock_count_low;
        logic [7:0]  clock_count_high;
        logic [15:0] fpga_line_count;
        logic        mode_settings_changed;
        logic        info_settings_changed;
        logic        restart;
    } frame_t;

    typedef struct packed {
        report_code_t status;
        logic         sync_up;
        logic [15:0]  total_lines;
        logic [11:0]  clocks_per_line;
        logic         progressive;
        logic         macrovision;
    } result_t;

endpackage

`default_nettype wire

@@ design/vssm_if.sv @@
// ----------------------------------------------------------------------------
// vssm_if
// Valid/ready channels for frame measurements and frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vssm_frame_if;
    import vssm_pkg::*;

    logic        valid;
    logic        ready;
    logic        sync_detected;
    logic [1:0]  vsync_mode;
    logic [7:0]  line_count_low;
    logic [7:0]  line_count_high;
    logic [7:0]  clock_count_low;
    logic [7:0]  clock_count_high;
    logic [15:0] fpga_line_count;
    logic        mode_settings_changed;
    logic        info_settings_changed;
    logic        restart;

    modport source (
        output valid, sync_detected, vsync_mode, line_count_low, line_count_high,
               clock_count_low, clock_count_high, fpga_line_count,
               mode_settings_changed, info_settings_changed, restart,
        input  ready
    );

    modport sink (
        input  valid, sync_detected, vsync_mode, line_count_low, line_count_high,
               clock_count_low, clock_count_high, fpga_line_count,
               mode_settings_changed, info_settings_changed, restart,
        output ready
    );
endinterface

interface vssm_result_if;
    import vssm_pkg::*;

    logic         valid;
    logic         ready;
    report_code_t status;
    logic         sync_up;
    logic [15:0]  total_lines;
    logic [11:0]  clocks_per_line;
    logic         progressive;
    logic         macrovision;

    modport source (
        output valid, status, sync_up, total_lines, clocks_per_line,
               progressive, macrovision,
        input  ready
    );

    modport sink (
        input  valid, status, sync_up, total_lines, clocks_per_line,
               progressive, macrovision,
        output ready
    );
endinterface

`default_nettype wire

@@ design/vssm_apb_regs.sv @@
// ----------------------------------------------------------------------------
// vssm_apb_regs
// APB register file holding the monitor thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vssm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vssm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vssm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output vssm_pkg::cfg_t                        cfg
);
    import vssm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_LINES_PROG: cfg_next.min_lines_prog = pwdata[11:0];
                REG_MIN_LINES_IL:   cfg_next.min_lines_il   = pwdata[11:0];
                REG_LOSS_THR:       cfg_next.loss_thr       = pwdata[3:0];
                REG_STABLE_THR:     cfg_next.stable_thr     = pwdata[3:0];
                REG_LINE_TOL:       cfg_next.line_tol       = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_LINES_PROG: prdata = {20'd0, cfg_reg.min_lines_prog};
            REG_MIN_LINES_IL:   prdata = {20'd0, cfg_reg.min_lines_il};
            REG_LOSS_THR:       prdata = {28'd0, cfg_reg.loss_thr};
            REG_STABLE_THR:     prdata = {28'd0, cfg_reg.stable_thr};
            REG_LINE_TOL:       prdata = {24'd0, cfg_reg.line_tol};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_lines_prog <= RST_MIN_LINES_PROG;
            cfg_reg.min_lines_il   <= RST_MIN_LINES_IL;
            cfg_reg.loss_thr       <= RST_LOSS_THR;
            cfg_reg.stable_thr     <= RST_STABLE_THR;
            cfg_reg.line_tol       <= RST_LINE_TOL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ design/vssm_frame_eval.sv @@
// ----------------------------------------------------------------------------
// vssm_frame_eval
// Per-frame evaluation: scan type, line check, loss and stability tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_frame_eval (
    input  vssm_pkg::cfg_t       cfg,
    input  vssm_pkg::mon_state_t st,
    input  vssm_pkg::frame_t     frame,
    output vssm_pkg::mon_state_t st_next,
    output vssm_pkg::result_t    res
);
    import vssm_pkg::*;

    logic [11:0] lines_reg_cnt;
    logic [12:0] lines_m1_x2;
    logic [11:0] clocks;
    logic        sync_eff;
    logic [11:0] pclk_eff;
    logic        force_prog;
    logic        il_hit;
    logic        prog;
    logic [15:0] lines;
    logic [11:0] min_sel;
    logic        frame_ok;
    logic [15:0] diff;
    logic        changed;
    logic [3:0]  stable_inc;
    logic        stable_hit;
    logic        act;
    logic        mode_raise;
    logic        sync_new;
    logic [3:0]  loss_new;
    logic [3:0]  stable_new;
    logic [11:0] pclk_new;

    assign lines_reg_cnt = {frame.line_count_high[3:0], frame.line_count_low};
    assign clocks        = {frame.clock_count_high[3:0], frame.clock_count_low};
    assign lines_m1_x2   = {lines_reg_cnt - 12'd1, 1'b0};

    // a restart drops sync and the stored clock count before anything else
    assign sync_eff = st.sync_state & ~frame.restart;
    assign pclk_eff = frame.restart ? 12'd0 : st.prev_clocks;

    assign force_prog = (frame.vsync_mode == VMODE_PROG)
                      || (!sync_eff && (lines_reg_cnt < cfg.min_lines_il));
    assign il_hit = (frame.vsync_mode == VMODE_IL_CHECK) && (lines_reg_cnt != 12'd0)
                  && (frame.fpga_line_count > {3'd0, lines_m1_x2});

    assign prog  = force_prog ? 1'b1 :
                   il_hit     ? 1'b0 : frame.line_count_high[LHI_PROG_BIT];
    assign lines = (!force_prog && il_hit) ? frame.fpga_line_count : {4'd0, lines_reg_cnt};

    assign min_sel  = prog ? cfg.min_lines_prog : cfg.min_lines_il;
    assign frame_ok = lines >= {4'd0, min_sel};

    assign diff    = (lines >= st.prev_lines) ? (lines - st.prev_lines)
                                              : (st.prev_lines - lines);
    assign changed = (diff > {8'd0, cfg.line_tol}) || (clocks != pclk_eff)
                   || (prog != st.prev_progressive);

    assign stable_inc = st.stable_counter + 4'd1;
    assign stable_hit = frame_ok && !changed && (st.stable_counter != cfg.stable_thr)
                      && (stable_inc == cfg.stable_thr);
    assign mode_raise = frame_ok && (stable_hit || frame.mode_settings_changed);

    // sync qualification
    always_comb
    begin
        act      = 1'b0;
        sync_new = sync_eff;
        loss_new = 4'd0;
        if (!sync_eff && frame.sync_detected && frame_ok)
        begin
            sync_new = 1'b1;
            act      = 1'b1;
        end
        else if (sync_eff && (!frame.sync_detected || !frame_ok))
        begin
            if (st.loss_counter >= cfg.loss_thr)
            begin
                sync_new = frame.sync_detected;
                act      = 1'b1;
            end
            else
            begin
                loss_new = st.loss_counter + 4'd1;
            end
        end
    end

    always_comb
    begin
        stable_new = st.stable_counter;
        if (frame_ok)
        begin
            if (changed)
                stable_new = 4'd0;
            else if (st.stable_counter != cfg.stable_thr)
                stable_new = stable_inc;
        end
        // mode gets reprogrammed, so the stable count is preset
        if ((act || mode_raise) && sync_new)
            stable_new = cfg.stable_thr;
    end

    always_comb
    begin
        pclk_new = frame_ok ? clocks : pclk_eff;
        if (act && !sync_new)
            pclk_new = 12'd0;
    end

    always_comb
    begin
        st_next.sync_state       = sync_new;
        st_next.loss_counter     = loss_new;
        st_next.stable_counter   = stable_new;
        st_next.prev_lines       = frame_ok ? lines : st.prev_lines;
        st_next.prev_clocks      = pclk_new;
        st_next.prev_progressive = frame_ok ? prog : st.prev_progressive;
    end

    always_comb
    begin
        if (act)
            res.status = ST_ACT;
        else if (mode_raise)
            res.status = ST_MODE;
        else if (frame.info_settings_changed)
            res.status = ST_INFO;
        else
            res.status = ST_NONE;
        res.sync_up         = st_next.sync_state;
        res.total_lines     = st_next.prev_lines;
        res.clocks_per_line = st_next.prev_clocks;
        res.progressive     = st_next.prev_progressive;
        res.macrovision     = frame.line_count_high[LHI_MACRO_BIT];
    end

endmodule

`default_nettype wire

@@ design/video_sync_stability_monitor.sv @@
// ----------------------------------------------------------------------------
// video_sync_stability_monitor
// Per-frame sync qualification and mode change detection for a video input.
// ----------------------------------------------------------------------------
// Usage
//   frame_in   : one transfer per video frame carrying the raw line/clock
//                count register bytes, the measured line count, vsync class,
//                sync-detect, settings-changed flags and a restart flag
//   result_out : one transfer per accepted frame with a prioritized status
//                code and the stored line count, clocks per line, scan type
//   APB port   : five threshold registers at byte addresses 0,4,8,12,16,
//                written with the usual setup/access pair, pready tied high;
//                write them only while no frame is in flight
// Pipeline and throughput
//   an accepted frame passes the single input register, the evaluation
//   logic and the result register; one frame per cycle sustained while
//   result_out takes every result
// Reset
//   rst_n clears the pipeline valids and the monitor state (sync down,
//   counters and stored counts at zero); registers take their defaults
// Stalls
//   a stalled result holds in the result register while the next frame
//   waits in the input register; frame_in.ready drops only when both hold
// ----------------------------------------------------------------------------
`default_nettype none

module video_sync_stability_monitor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    vssm_frame_if.sink                            frame_in,
    vssm_result_if.source                         result_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vssm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vssm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vssm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import vssm_pkg::*;

    cfg_t       cfg;

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    frame_t     in_frame_reg;
    frame_t     in_frame_next;
    frame_t     frame_bus;

    // monitor state
    mon_state_t state_reg;
    mon_state_t state_next;
    mon_state_t eval_state;

    // result stage
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    result_t    out_res_next;
    result_t    eval_res;

    logic       in_xfer;
    logic       advance;

    vssm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vssm_frame_eval u_eval (
        .cfg     (cfg),
        .st      (state_reg),
        .frame   (in_frame_reg),
        .st_next (eval_state),
        .res     (eval_res)
    );

    // gather the channel fields into one frame word
    always_comb
    begin
        frame_bus.sync_detected         = frame_in.sync_detected;
        frame_bus.vsync_mode            = frame_in.vsync_mode;
        frame_bus.line_count_low        = frame_in.line_count_low;
        frame_bus.line_count_high       = frame_in.line_count_high;
        frame_bus.clock_count_low       = frame_in.clock_count_low;
        frame_bus.clock_count_high      = frame_in.clock_count_high;
        frame_bus.fpga_line_count       = frame_in.fpga_line_count;
        frame_bus.mode_settings_changed = frame_in.mode_settings_changed;
        frame_bus.info_settings_changed = frame_in.info_settings_changed;
        frame_bus.restart               = frame_in.restart;
    end

    // the buffered frame moves on whenever the result register is free or
    // being drained this cycle; state is committed at that same edge, so the
    // next frame always sees the state left by the one before it
    assign advance        = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign frame_in.ready = !in_valid_reg || advance;
    assign in_xfer        = frame_in.valid && frame_in.ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_frame_next  = in_frame_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        state_next     = state_reg;

        if (advance)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_res_next   = eval_res;
            state_next     = eval_state;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_xfer)
        begin
            in_valid_next = 1'b1;
            in_frame_next = frame_bus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        in_frame_reg <= in_frame_next;
        out_res_reg  <= out_res_next;
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.status          = out_res_reg.status;
    assign result_out.sync_up         = out_res_reg.sync_up;
    assign result_out.total_lines     = out_res_reg.total_lines;
    assign result_out.clocks_per_line = out_res_reg.clocks_per_line;
    assign result_out.progressive     = out_res_reg.progressive;
    assign result_out.macrovision     = out_res_reg.macrovision;

endmodule

`default_nettype wire

@@ design/vssm_checker.sv @@
// ----------------------------------------------------------------------------
// vssm_checker
// Port-level checks for the video sync stability monitor.
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_checker (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_ready,
    input  wire logic                    out_valid,
    input  wire logic                    out_ready,
    input  wire vssm_pkg::report_code_t  out_status,
    input  wire logic                    out_sync_up,
    input  wire logic [15:0]             out_total_lines,
    input  wire logic [11:0]             out_clocks_per_line
);
    import vssm_pkg::*;

    // a stalled result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its status, sync flag, line count and clock count
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_total_lines)
            && $stable(out_clocks_per_line) && $stable(out_sync_up))
        else $error("result payload changed while stalled");

    // with the result register empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("frame input stalled with empty result stage");

    // a reported sync loss clears the stored clock count
    a_loss_clears_clocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_ACT) && !out_sync_up
            |-> (out_clocks_per_line == 12'd0))
        else $error("clock count kept across sync loss");

endmodule

bind video_sync_stability_monitor vssm_checker u_vssm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ready            (frame_in.ready),
    .out_valid           (result_out.valid),
    .out_ready           (result_out.ready),
    .out_status          (result_out.status),
    .out_sync_up         (result_out.sync_up),
    .out_total_lines     (result_out.total_lines),
    .out_clocks_per_line (result_out.clocks_per_line)
);

`default_nettype wire
